>>> rtl/edcrc_pkg.sv
// shared types, constants and the crc byte update for the envelope deframer
package edcrc_pkg;

    // frame layout and counter limits
    localparam int unsigned MIN_FRAME = 13;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic CFG_PREAMBLE_FIRST  = 1'b0;
    localparam logic CFG_PREAMBLE_SECOND = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_PREAMBLE = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_CRC      = 3'd4
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        t_status     status_code;
        logic [7:0]  service_id;
        logic [7:0]  flag_byte;
        logic [7:0]  sequence_number;
        logic [31:0] magic_word;
        logic [15:0] payload_length;
        logic        last_of_run;
    } t_result;

    // up to two results written into the queue in one cycle, first one first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/edcrc_core.sv
// input register, frame state and result generation for one byte per cycle while the result queue has room
module edcrc_core import edcrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_eof,
    output logic        o_ready,
    input  logic        i_space_ok,
    output t_push       o_push
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eof;

    logic [7:0]  r_pre_first;
    logic [7:0]  r_pre_second;

    logic [16:0] r_count,  n_count;
    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_dly0,   n_dly0;
    logic [7:0]  r_dly1,   n_dly1;
    logic        r_pok,    n_pok;
    logic [15:0] r_decl,   n_decl;
    logic [7:0]  r_sid,    n_sid;
    logic [7:0]  r_flag,   n_flag;
    logic [7:0]  r_seq,    n_seq;
    logic [31:0] r_magic,  n_magic;

    logic        proc;
    logic [17:0] len;
    logic [15:0] crc_upd;
    logic [15:0] rcv;
    t_status     status;
    t_result     pay_res;
    t_result     stat_res;

    assign proc    = r_in_valid && i_space_ok;
    assign o_ready = !r_in_valid || i_space_ok;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_eof  <= i_eof;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_first  <= 8'h00;
            r_pre_second <= 8'h00;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PREAMBLE_FIRST:  r_pre_first  <= i_cfg_data;
                CFG_PREAMBLE_SECOND: r_pre_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // crc over the byte leaving the delay line
    assign crc_upd = crc_byte(r_crc, r_dly1);
    assign len     = {1'b0, r_count} + 18'd1;
    assign rcv     = {r_dly0, r_in_byte};

    // header capture and frame state update
    always_comb begin
        n_count = (r_count < COUNT_MAX) ? r_count + 17'd1 : r_count;
        n_crc   = r_crc;
        n_dly0  = r_in_byte;
        n_dly1  = r_dly0;
        n_pok   = r_pok;
        n_decl  = r_decl;
        n_sid   = r_sid;
        n_flag  = r_flag;
        n_seq   = r_seq;
        n_magic = r_magic;

        if (r_count >= 17'd2) begin
            n_crc = crc_upd;
        end
        if (r_count == 17'd0 && r_in_byte != r_pre_first) begin
            n_pok = 1'b0;
        end
        if (r_count == 17'd1 && r_in_byte != r_pre_second) begin
            n_pok = 1'b0;
        end
        if (r_count == 17'd2)  n_decl[7:0]   = r_in_byte;
        if (r_count == 17'd3)  n_decl[15:8]  = r_in_byte;
        if (r_count == 17'd4)  n_sid         = r_in_byte;
        if (r_count == 17'd5)  n_flag        = r_in_byte;
        if (r_count == 17'd6)  n_seq         = r_in_byte;
        if (r_count == 17'd7)  n_magic[7:0]   = r_in_byte;
        if (r_count == 17'd8)  n_magic[15:8]  = r_in_byte;
        if (r_count == 17'd9)  n_magic[23:16] = r_in_byte;
        if (r_count == 17'd10) n_magic[31:24] = r_in_byte;
    end

    // status checks in priority order
    always_comb begin
        if (len < 18'(MIN_FRAME)) begin
            status = ST_SHORT;
        end else if (!n_pok) begin
            status = ST_PREAMBLE;
        end else if ({2'b00, n_decl} != len) begin
            status = ST_LENGTH;
        end else if (rcv != n_crc) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end
    end

    // result items
    always_comb begin
        pay_res              = '0;
        pay_res.kind         = KIND_PAYLOAD;
        pay_res.payload_byte = r_dly1;
        pay_res.status_code  = ST_OK;
        pay_res.last_of_run  = !r_in_eof;

        stat_res             = '0;
        stat_res.kind        = KIND_STATUS;
        stat_res.status_code = status;
        stat_res.last_of_run = 1'b1;
        if (status == ST_OK) begin
            stat_res.service_id      = n_sid;
            stat_res.flag_byte       = n_flag;
            stat_res.sequence_number = n_seq;
            stat_res.magic_word      = n_magic;
            stat_res.payload_length  = 16'(len - 18'(MIN_FRAME));
        end
    end

    // payload goes first when both results are due
    always_comb begin
        o_push = '0;
        if (r_count >= 17'(MIN_FRAME)) begin
            o_push.first  = pay_res;
            o_push.second = stat_res;
            o_push.cnt    = r_in_eof ? 2'd2 : 2'd1;
        end else begin
            o_push.first  = stat_res;
            o_push.second = stat_res;
            o_push.cnt    = r_in_eof ? 2'd1 : 2'd0;
        end
        if (!proc) begin
            o_push.cnt = 2'd0;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_dly0  <= '0;
            r_dly1  <= '0;
            r_pok   <= 1'b1;
            r_decl  <= '0;
            r_sid   <= '0;
            r_flag  <= '0;
            r_seq   <= '0;
            r_magic <= '0;
        end else if (proc) begin
            if (r_in_eof) begin
                r_count <= '0;
                r_crc   <= CRC_INIT;
                r_dly0  <= '0;
                r_dly1  <= '0;
                r_pok   <= 1'b1;
                r_decl  <= '0;
                r_sid   <= '0;
                r_flag  <= '0;
                r_seq   <= '0;
                r_magic <= '0;
            end else begin
                r_count <= n_count;
                r_crc   <= n_crc;
                r_dly0  <= n_dly0;
                r_dly1  <= n_dly1;
                r_pok   <= n_pok;
                r_decl  <= n_decl;
                r_sid   <= n_sid;
                r_flag  <= n_flag;
                r_seq   <= n_seq;
                r_magic <= n_magic;
            end
        end
    end

endmodule

>>> rtl/edcrc_fifo.sv
// small result queue taking up to two items per cycle and giving one while the reader is ready
module edcrc_fifo import edcrc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_space_ok,
    output logic    o_valid,
    output t_result o_item,
    input  logic    i_ready
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;
    logic                 pop;

    assign o_valid    = r_count != '0;
    assign o_item     = r_mem[r_rd_ptr];
    assign pop        = o_valid && i_ready;
    // room for the worst case of two items from the core
    assign o_space_ok = r_count <= FIFO_CW'(FIFO_DEPTH - 2);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_push.second;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(pop);
            r_count  <= r_count + FIFO_CW'(i_push.cnt) - FIFO_CW'(pop);
        end
    end

endmodule

>>> rtl/envelope_deframer_crc16_top.sv
// top level of the crc-16 envelope deframer
// Frame bytes enter one per cycle on the slave stream, tlast on the final byte
// of a frame. Each byte is registered, run through the byte-wide crc update
// and the header and length checks in one pass, and its results (none, a
// forwarded payload byte, a status, or a payload byte then a status on the
// final byte) are written into a four-entry result queue. The sustained rate
// is one byte per cycle; a final byte that yields two results writes both into
// the queue together, and the slave side holds tready low while a byte waits in
// the input register and the queue has fewer than two free entries. A result is
// offered on the master stream once its byte has left the input register and
// entered the queue. Payload bytes are forwarded with a two-byte delay before
// the frame is validated. Preamble registers are written through the plain write
// port by the user only while no frame is in flight; the block does not enforce it.
module envelope_deframer_crc16_top import edcrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // in_byte
    input  logic        i_s_axis_tlast,   // end_of_frame
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // payload_byte, status_code, service_id, flag_byte, sequence_number,
    // magic_word, payload_length, zero fill
    output logic [87:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // result_kind
    output logic        o_m_axis_tlast    // last_of_run
);

    t_push   push;
    logic    space_ok;
    t_result item;

    edcrc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .i_byte     (i_s_axis_tdata),
        .i_eof      (i_s_axis_tlast),
        .o_ready    (o_s_axis_tready),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    edcrc_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_m_axis_tvalid),
        .o_item     (item),
        .i_ready    (i_m_axis_tready)
    );

    // output packing
    assign o_m_axis_tdata = {5'b00000, item.payload_length, item.magic_word,
                             item.sequence_number, item.flag_byte, item.service_id,
                             item.status_code, item.payload_byte};
    assign o_m_axis_tuser = item.kind;
    assign o_m_axis_tlast = item.last_of_run;

    // a status always closes the run of its byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("status result without last_of_run");

    // payload results carry no status and no header
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[87:8] == 80'h0)
        else $error("payload result with nonzero status or header fields");

    // a failed frame reports no header fields
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser && o_m_axis_tdata[10:8] != 3'd0
        |-> o_m_axis_tdata[87:11] == 77'h0 && o_m_axis_tdata[7:0] == 8'h00)
        else $error("failed status carries header fields");

    // a status code never goes past crc mismatch
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[10:8] <= 3'd4)
        else $error("status code out of range");

endmodule
